@@ rtl/wvm_pkg.sv @@
`timescale 1ns / 1ps
package wvm_pkg;
    localparam logic [1:0] OP_FRAME = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_SETUP = 2'd2;
    localparam logic [0:0] CFG_MASTER_L = 1'b0;
    localparam logic [0:0] CFG_MASTER_R = 1'b1;
    localparam int CLIP_LIMIT = 32767;
    localparam logic [14:0] UNITY_GAIN = 15'd4096;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [2:0]         voice_sel;
        logic [11:0]        sample_addr;
        logic signed [15:0] sample_value;
        logic [11:0]        src_begin;
        logic [12:0]        src_end;
        logic [15:0]        dest_length;
        logic [12:0]        voice_length;
        logic [14:0]        amp_left;
        logic [14:0]        amp_right;
        logic               repeat_mode;
        logic               engage;
    } t_in;

    typedef struct packed {
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
    } t_out;

    // voice record held in the voice memory
    typedef struct packed {
        logic        engaged;
        logic        rpt;
        logic [15:0] pos;
        logic [11:0] vbegin;
        logic [12:0] vend;
        logic [15:0] dlen;
        logic [12:0] wlen;
        logic [14:0] gain_l;
        logic [14:0] gain_r;
    } t_voice;

    localparam int VOICE_W = $bits(t_voice);

    function automatic t_voice voice_reset();
        t_voice v;
        v.engaged = 1'b0;
        v.rpt     = 1'b1;
        v.pos     = 16'd0;
        v.vbegin  = 12'd0;
        v.vend    = 13'd0;
        v.dlen    = 16'd1;
        v.wlen    = 13'd1;
        v.gain_l  = UNITY_GAIN;
        v.gain_r  = UNITY_GAIN;
        return v;
    endfunction
endpackage

@@ rtl/wavetable_voice_mixer_core.sv @@
`timescale 1ns / 1ps
// A frame transaction walks the voices one at a time: per engaged voice a read of the voice
// memory, a 29-step serial divide for the source index, a sample memory read and two gain
// steps, while an idle voice is read and skipped; the master gain stage and output follow
// the last voice. Sample writes and voice set up each make one memory write. The voice and
// sample memories are not cleared: after reset a pass loads a default voice record into
// every voice entry while input is held off.
module wavetable_voice_mixer_core
    import wvm_pkg::*;
#(
    parameter int VOICES       = 8,
    parameter int SAMPLE_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [14:0] i_cfg_data
);
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int AW = $clog2(SAMPLE_DEPTH);
    localparam int SW = VW + AW;
    localparam int SUMW = 16 + $clog2(VOICES + 1) + 1;
    localparam int DIVK = VOICES * 4096;

    localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_VRD = 4'd2, S_VCHK = 4'd3,
        S_DIV = 4'd4, S_ADDR = 4'd5, S_SRD = 4'd6, S_MUL = 4'd7, S_ACC = 4'd8,
        S_NEXT = 4'd9, S_MST = 4'd10, S_MST2 = 4'd11, S_OUT = 4'd12, S_SDIV = 4'd13;

    logic [3:0]  r_state;
    logic [VW:0] r_v;
    t_in         r_in;
    logic [14:0] r_mgl, r_mgr;

    logic          w_vwe;
    logic [VW-1:0] w_vwaddr, w_vraddr;
    t_voice        w_vwdata, w_vrd;
    logic          w_swe;
    logic [SW-1:0] w_swaddr, w_sraddr;
    logic [15:0]   w_srd;

    t_voice r_voice;
    logic signed [29:0] r_num;
    logic               w_dstart, w_ddone;
    logic signed [29:0] w_quot;
    logic signed [31:0] r_idx;
    logic [AW-1:0]      r_addr;
    logic signed [31:0] r_pl, r_pr;
    logic signed [SUMW-1:0] r_suml, r_sumr;
    logic signed [SUMW+16:0] r_ml, r_mr;
    logic signed [15:0] r_ol, r_or;
    logic signed [31:0] w_idx1;

    wvm_ram #(.WIDTH(VOICE_W), .DEPTH(1 << VW)) u_vmem (
        .i_clk(i_clk), .i_we(w_vwe), .i_waddr(w_vwaddr), .i_wdata(w_vwdata),
        .i_raddr(w_vraddr), .o_rdata(w_vrd));

    wvm_ram #(.WIDTH(16), .DEPTH(1 << SW)) u_smem (
        .i_clk(i_clk), .i_we(w_swe), .i_waddr(w_swaddr), .i_wdata(r_in.sample_value),
        .i_raddr(w_sraddr), .o_rdata(w_srd));

    wvm_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart), .i_num(r_num),
        .i_den(r_voice.dlen), .o_done(w_ddone), .o_quot(w_quot));

    function automatic logic signed [31:0] clip32(input logic signed [47:0] x);
        if (x > 48'sd32767) return 32'sd32767;
        if (x < -48'sd32767) return -32'sd32767;
        return 32'(x);
    endfunction

    function automatic logic signed [47:0] tdiv(input logic signed [47:0] x, input int sh);
        logic signed [47:0] a;
        a = x[47] ? -x : x;
        a = a >>> sh;
        return x[47] ? -a : a;
    endfunction

    assign o_ready = (r_state == S_IDLE) && !o_valid;
    assign w_dstart = (r_state == S_SDIV);
    assign w_vraddr = r_v[VW-1:0];
    assign w_sraddr = {r_v[VW-1:0], r_addr};
    assign w_swe    = (r_state == S_VRD) && (r_in.opcode == OP_WRITE) && (r_v < VOICES);
    assign w_swaddr = {r_in.voice_sel[VW-1:0], r_in.sample_addr[AW-1:0]};
    assign w_idx1   = {{20{1'b0}}, r_voice.vbegin} + 32'(w_quot);

    always_comb begin
        t_voice nv;
        logic [16:0] np;
        nv = r_voice;
        np = {1'b0, r_voice.pos} + 17'd1;
        if (np >= {1'b0, r_voice.dlen}) begin
            np = '0;
            if (!r_voice.rpt) nv.engaged = 1'b0;
        end
        nv.pos = np[15:0];
        w_vwe = 1'b0;
        w_vwaddr = r_v[VW-1:0];
        w_vwdata = nv;
        if (r_state == S_CLEAR) begin
            w_vwe = 1'b1;
            w_vwdata = voice_reset();
        end else if (r_state == S_VRD && r_in.opcode == OP_SETUP && r_v < VOICES) begin
            w_vwe = 1'b1;
            w_vwdata.engaged = r_in.engage;
            w_vwdata.rpt     = r_in.repeat_mode;
            w_vwdata.pos     = 16'd0;
            w_vwdata.vbegin  = r_in.src_begin;
            w_vwdata.vend    = r_in.src_end;
            w_vwdata.dlen    = (r_in.dest_length == 16'd0) ? 16'd1 : r_in.dest_length;
            w_vwdata.wlen    = r_in.voice_length;
            w_vwdata.gain_l  = r_in.amp_left;
            w_vwdata.gain_r  = r_in.amp_right;
        end else if (r_state == S_ACC) begin
            w_vwe = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mgl <= UNITY_GAIN;
            r_mgr <= UNITY_GAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MASTER_L: r_mgl <= i_cfg_data;
                CFG_MASTER_R: r_mgr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_v     <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready) o_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    if (r_v == (VW + 1)'(VOICES - 1) || r_v[VW-1:0] == '1) begin
                        r_v <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_v <= r_v + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_in <= i_data;
                        r_suml <= '0;
                        r_sumr <= '0;
                        if (i_data.opcode == OP_FRAME) begin
                            r_v <= '0;
                            r_state <= S_VCHK;
                        end else begin
                            r_v <= {1'b0, i_data.voice_sel[VW-1:0]} |
                                   ((VW + 1)'(i_data.voice_sel >> VW) << VW);
                            r_state <= S_VRD;
                        end
                    end
                end
                S_VRD: r_state <= S_IDLE;
                S_VCHK: r_state <= S_DIV;
                S_DIV: begin
                    r_voice <= w_vrd;
                    r_num <= 30'(signed'({14'd0, w_vrd.pos}) *
                                  (signed'({1'b0, w_vrd.vend}) - signed'({2'b0, w_vrd.vbegin})));
                    r_state <= w_vrd.engaged ? S_SDIV : S_NEXT;
                end
                S_SDIV: r_state <= S_ADDR;
                S_ADDR: begin
                    if (w_ddone) begin
                        r_idx <= (w_idx1 >= signed'({19'd0, r_voice.wlen}))
                                 ? w_idx1 - signed'({19'd0, r_voice.wlen}) : w_idx1;
                        r_state <= S_SRD;
                    end
                end
                S_SRD: begin
                    r_addr <= r_idx[AW-1:0];
                    r_state <= S_MUL;
                end
                S_MUL: r_state <= S_ACC;
                S_ACC: begin
                    r_pl <= signed'(w_srd) * signed'({1'b0, r_voice.gain_l});
                    r_pr <= signed'(w_srd) * signed'({1'b0, r_voice.gain_r});
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (r_voice.engaged) begin
                        r_suml <= r_suml + SUMW'(clip32(tdiv(48'(r_pl), 12)));
                        r_sumr <= r_sumr + SUMW'(clip32(tdiv(48'(r_pr), 12)));
                    end
                    r_voice.engaged <= 1'b0;
                    if (r_v == (VW + 1)'(VOICES - 1)) begin
                        r_state <= S_MST;
                    end else begin
                        r_v <= r_v + 1'b1;
                        r_state <= S_VCHK;
                    end
                end
                S_MST: begin
                    r_ml <= r_suml * signed'({1'b0, r_mgl});
                    r_mr <= r_sumr * signed'({1'b0, r_mgr});
                    r_state <= S_MST2;
                end
                S_MST2: begin
                    r_ol <= 16'(clip32(48'(r_ml) / DIVK));
                    r_or <= 16'(clip32(48'(r_mr) / DIVK));
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!o_valid) begin
                        o_valid <= 1'b1;
                        o_data.left_sample <= r_ol;
                        o_data.right_sample <= r_or;
                        r_v <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rst_n && r_state == S_IDLE) begin
            assert (!w_vwe) else $error("voice write while idle");
        end
    end

    ap_out_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !o_valid) |=> o_valid)
        else $error("frame result lost");
    ap_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready)
        else $error("accepted while busy");
    ap_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !w_swe)
        else $error("sample write during clear");
endmodule

@@ rtl/wvm_ram.sv @@
`timescale 1ns / 1ps
module wvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/wvm_divider.sv @@
`timescale 1ns / 1ps
// signed restoring divider, floor quotient of a 30-bit numerator by a 16-bit divisor
module wvm_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [29:0] i_num,
    input  logic [15:0]        i_den,
    output logic               o_done,
    output logic signed [29:0] o_quot
);
    logic [28:0] r_q, n_q;
    logic [16:0] r_rem, n_rem;
    logic [15:0] r_den;
    logic        r_neg;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [17:0] w_trial;
    logic [29:0] w_qpos;

    always_comb begin
        w_trial = {r_rem, r_q[28]} - {2'b00, r_den};
        if (!w_trial[17]) begin
            n_rem = w_trial[16:0];
            n_q   = {r_q[27:0], 1'b1};
        end else begin
            n_rem = {r_rem[15:0], r_q[28]};
            n_q   = {r_q[27:0], 1'b0};
        end
        w_qpos = {1'b0, r_q};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd29;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[29];
            r_q   <= i_num[29] ? 29'(-i_num) : i_num[28:0];
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    always_comb begin
        if (!r_neg) begin
            o_quot = w_qpos;
        end else begin
            o_quot = (r_rem != 17'd0) ? -w_qpos - 30'sd1 : -w_qpos;
        end
    end
endmodule
